// ----- rtl/nptt_pkg.sv -----
// Shared types, constants and helpers for the NAT port translation table.
// No dependencies; the interface, top-level and checker files import this package.
`timescale 1ns / 1ps
`default_nettype none
package nptt_pkg;

	localparam int TableEntries = 4096;
	localparam int AddrW = $clog2(TableEntries);
	localparam int CountW = AddrW + 1;

	localparam logic [7:0] ProtoTcp = 8'd6;
	localparam logic [7:0] ProtoUdp = 8'd17;

	localparam logic [15:0] PortFirstReset = 16'd32768;
	localparam logic [15:0] PortLimitReset = 16'd61000;

	typedef enum logic [1:0] {
		CFG_NIC_ADDRESS = 2'd0,
		CFG_PORT_FIRST  = 2'd1,
		CFG_PORT_LIMIT  = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ACT_PASS   = 2'd0,
		ACT_XLATE  = 2'd1,
		ACT_FULL   = 2'd2,
		ACT_NOMAP  = 2'd3
	} action_t;

	localparam logic [1:0] OffloadNone = 2'd0;
	localparam logic [1:0] OffloadTcp  = 2'd1;
	localparam logic [1:0] OffloadUdp  = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic        is_ipv4;
		logic [7:0]  protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [63:0] header_front;
		logic [7:0]  time_to_live;
		logic [11:0] vm_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] new_source_address;
		logic [31:0] new_dest_address;
		logic [15:0] new_source_port;
		logic [15:0] new_dest_port;
		logic [15:0] header_checksum;
		logic [11:0] target_vm;
		logic [1:0]  l4_offload;
	} rsp_t;

	typedef struct packed {
		logic [47:0] inner;
		logic [47:0] outside;
		logic        udp;
		logic [11:0] vm;
		logic [15:0] xlat_port;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	// Sum of the nine non-zero header words before folding.
	function automatic logic [19:0] hdr_sum(input logic [63:0] front, input logic [7:0] ttl,
			input logic [7:0] proto, input logic [31:0] src, input logic [31:0] dst);
		logic [19:0] s;
		s = 20'(front[15:0]) + 20'(front[31:16]) + 20'(front[47:32]) + 20'(front[63:48]);
		s = s + 20'({ttl, proto}) + 20'(src[31:16]) + 20'(src[15:0]);
		s = s + 20'(dst[31:16]) + 20'(dst[15:0]);
		return s;
	endfunction

	function automatic logic [15:0] hdr_fold(input logic [19:0] s);
		logic [16:0] a;
		logic [15:0] b;
		a = 17'(s[15:0]) + 17'(s[19:16]);
		b = a[15:0] + 16'(a[16]);
		return ~b;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/nptt_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on nptt_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface nptt_req_if import nptt_pkg::*; ;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface nptt_rsp_if import nptt_pkg::*; ;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/nptt_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nptt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/nat_port_translation_table_top.sv -----
// A lookup ends at the first matching entry scanned, or after all stored entries on a miss.
// One request at a time: the next is accepted once the block is back in IDLE after the result
// register loads; a result not yet taken holds the block in DONE.
// Reset clears the fill count and the result valid, and returns the NAT port counter and
// configuration registers to their reset values; the table RAM itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module nat_port_translation_table_top import nptt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	nptt_req_if.sink        req,
	nptt_rsp_if.source      rsp
);
	// Control flow: IDLE takes a request, SCAN walks the table (forward for
	// outbound so the oldest entry wins, backward for inbound so the newest
	// wins), CSUM adds the header words, DONE folds the checksum and hands the
	// result to the output register.
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CSUM, ST_DONE} state_t;

	state_t            state_q;
	req_t              req_q;
	logic              handled_q;
	logic              udp_q;
	logic [31:0]       nic_q;
	logic [15:0]       port_first_q;
	logic [15:0]       port_limit_q;
	logic [15:0]       next_port_q;
	logic [CountW-1:0] fill_q;
	logic [CountW-1:0] cnt_q;
	logic [AddrW-1:0]  idx_q;
	logic              chk_s1;
	rsp_t              res_q;
	logic [19:0]       sum_q;
	rsp_t              rsp_q;
	logic              rsp_vld_q;

	// Table RAM holds one whole entry per row.
	logic              ram_we;
	logic [AddrW-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	entry_t            ram_rdata;

	nptt_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	logic        in_handled;
	logic        match;
	logic        resolve;
	logic        table_full;
	logic [15:0] port_inc;
	logic [15:0] port_after;
	logic [47:0] key;
	rsp_t        res_d;
	logic        rsp_load;
	rsp_t        rsp_d;

	assign in_handled = req.payload.is_ipv4 &&
		(req.payload.protocol == ProtoTcp || req.payload.protocol == ProtoUdp);
	assign key = {req_q.source_address, req_q.source_port};
	assign table_full = (fill_q == CountW'(TableEntries));
	assign port_inc = next_port_q + 16'd1;
	assign port_after = (port_inc >= port_limit_q) ? port_first_q : port_inc;

	// A read issued last cycle is compared now.
	always_comb begin
		if (!req_q.cmd) begin
			match = chk_s1 && ram_rdata.inner == key && ram_rdata.udp == udp_q;
		end else begin
			match = chk_s1 && ram_rdata.outside == key && ram_rdata.udp == udp_q &&
				ram_rdata.xlat_port == req_q.dest_port;
		end
	end

	assign resolve = (state_q == ST_SCAN) && (match || (cnt_q == '0 && !chk_s1));
	assign ram_re = (state_q == ST_SCAN) && cnt_q != '0;

	// Outcome of the lookup, and the insert on an outbound miss.
	always_comb begin
		res_d.action = ACT_PASS;
		res_d.new_source_address = req_q.source_address;
		res_d.new_dest_address = req_q.dest_address;
		res_d.new_source_port = req_q.source_port;
		res_d.new_dest_port = req_q.dest_port;
		res_d.header_checksum = '0;
		res_d.target_vm = '0;
		res_d.l4_offload = OffloadNone;
		ram_we = 1'b0;
		ram_waddr = fill_q[AddrW-1:0];
		ram_wdata.inner = key;
		ram_wdata.outside = {req_q.dest_address, req_q.dest_port};
		ram_wdata.udp = udp_q;
		ram_wdata.vm = req_q.vm_id;
		ram_wdata.xlat_port = next_port_q;
		if (handled_q) begin
			if (!req_q.cmd) begin
				if (match) begin
					res_d.action = ACT_XLATE;
					res_d.new_source_address = nic_q;
					res_d.new_source_port = ram_rdata.xlat_port;
				end else if (!table_full) begin
					ram_we = resolve;
					res_d.action = ACT_XLATE;
					res_d.new_source_address = nic_q;
					res_d.new_source_port = next_port_q;
				end else begin
					res_d.action = ACT_FULL;
				end
			end else if (match) begin
				res_d.action = ACT_XLATE;
				res_d.new_dest_address = ram_rdata.inner[47:16];
				res_d.new_dest_port = ram_rdata.inner[15:0];
				res_d.target_vm = ram_rdata.vm;
			end else begin
				res_d.action = ACT_NOMAP;
			end
		end
		if (res_d.action == ACT_XLATE) begin
			res_d.l4_offload = udp_q ? OffloadUdp : OffloadTcp;
		end
	end

	// The output register loads once it is empty or its result is taken this cycle.
	assign rsp_load = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		rsp_d = res_q;
		if (res_q.action == ACT_XLATE) begin
			rsp_d.header_checksum = hdr_fold(sum_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nic_q <= '0;
			port_first_q <= PortFirstReset;
			port_limit_q <= PortLimitReset;
			next_port_q <= PortFirstReset;
			fill_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			chk_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
			handled_q <= 1'b0;
			udp_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_NIC_ADDRESS: nic_q <= cfg_data;
					CFG_PORT_FIRST:  port_first_q <= cfg_data[15:0];
					CFG_PORT_LIMIT:  port_limit_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			rsp_vld_q <= rsp_load || (rsp_vld_q && !rsp.ready);
			case (state_q)
				ST_IDLE: begin
					chk_s1 <= 1'b0;
					if (req.valid) begin
						req_q <= req.payload;
						handled_q <= in_handled;
						udp_q <= (req.payload.protocol == ProtoUdp);
						cnt_q <= in_handled ? fill_q : '0;
						idx_q <= req.payload.cmd ? fill_q[AddrW-1:0] - AddrW'(1) : '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (resolve) begin
						chk_s1 <= 1'b0;
						res_q <= res_d;
						if (handled_q && !req_q.cmd && !match) begin
							next_port_q <= port_after;
							if (!table_full) begin
								fill_q <= fill_q + CountW'(1);
							end
						end
						state_q <= ST_CSUM;
					end else begin
						chk_s1 <= ram_re;
						if (ram_re) begin
							cnt_q <= cnt_q - CountW'(1);
							idx_q <= req_q.cmd ? idx_q - AddrW'(1) : idx_q + AddrW'(1);
						end
					end
				end
				ST_CSUM: begin
					sum_q <= hdr_sum(req_q.header_front, req_q.time_to_live, req_q.protocol,
						res_q.new_source_address, res_q.new_dest_address);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						rsp_q <= rsp_d;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.payload = rsp_q;

endmodule
`default_nettype wire

// ----- rtl/nptt_chk.sv -----
// Port-level checker for the NAT translation table, bound to the top level.
// Depends on nptt_pkg for action and offload codes.
`timescale 1ns / 1ps
`default_nettype none
module nptt_chk import nptt_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] action,
	input wire logic [15:0] header_checksum,
	input wire logic [11:0] target_vm,
	input wire logic [1:0] l4_offload
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	a_untranslated_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && action != ACT_XLATE |->
		header_checksum == '0 && l4_offload == OffloadNone && target_vm == '0)
		else $error("untranslated result carries translation fields");

	a_xlate_offload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && action == ACT_XLATE |-> l4_offload == OffloadTcp || l4_offload == OffloadUdp)
		else $error("translated result without offload request");
endmodule

bind nat_port_translation_table_top nptt_chk u_nptt_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.action          (rsp.payload.action),
	.header_checksum (rsp.payload.header_checksum),
	.target_vm       (rsp.payload.target_vm),
	.l4_offload      (rsp.payload.l4_offload)
);
`default_nettype wire
